@@ hw/rtl/byte_stuffed_frame_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the byte stuffed frame receiver
// Clocked property checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTH
// Property checked on every rising clock edge while out of reset.
`define BSFR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("bsfr assertion failed");
// Property that must never hold.
`define BSFR_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("bsfr forbidden condition");
`else
`define BSFR_ASSERT(label, clk, rst_n, prop)
`define BSFR_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ hw/rtl/bsfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte stuffed frame receiver package
// Framing bytes, escape codes, event codes and deframer states.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned EventW = 3;

  // Line framing bytes
  localparam logic [ByteW-1:0] StartByte  = 8'hA2;
  localparam logic [ByteW-1:0] EndByte    = 8'hA3;
  localparam logic [ByteW-1:0] AbortByte  = 8'hA4;
  localparam logic [ByteW-1:0] EscapeByte = 8'hAA;

  // Codes that follow an escape
  localparam logic [ByteW-1:0] CodeStart  = 8'h02;
  localparam logic [ByteW-1:0] CodeEnd    = 8'h03;
  localparam logic [ByteW-1:0] CodeAbort  = 8'h04;
  localparam logic [ByteW-1:0] CodeEscape = 8'h0A;

  typedef enum logic [EventW-1:0] {
    EV_NONE    = 3'd0,
    EV_DATA    = 3'd1,
    EV_END     = 3'd2,
    EV_ABORT   = 3'd3,
    EV_RESTART = 3'd4,
    EV_ESCERR  = 3'd5,
    EV_START   = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FRAME = 2'd1,
    ST_ESC   = 2'd2
  } state_e;

endpackage

@@ hw/rtl/byte_stuffed_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// Byte stuffed frame receiver
// Strips start/end/abort/escape framing from a raw line byte stream and
// emits one event word (with decoded payload byte) per line byte.
// ----------------------------------------------------------------------------
//  channel   dir  tdata           tuser
//  s_axis    in   raw_byte[7:0]   -
//  m_axis    out  data_byte[7:0]  event_res[2:0]
//
//  One word per cycle sustained while m_axis is not stalled; the path runs
//  through the input register, decode and the result register. Every line
//  byte gives exactly one result word. Reset returns the deframer to idle
//  and empties both registers. A stall on m_axis holds the result register;
//  the input register keeps one more word, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_receiver_assert.svh"

module byte_stuffed_frame_receiver
  import bsfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,   // [7:0] raw_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ByteW-1:0]  m_axis_tdata,   // [7:0] data_byte
  output logic [EventW-1:0] m_axis_tuser    // [2:0] event_res
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  event_e           ev_q;
  logic [ByteW-1:0] data_q;
  state_e           state_q, state_d;
  event_e           ev_d;
  logic [ByteW-1:0] data_d;
  logic             out_load;
  logic             in_load;

  // Result register frees when empty or being drained
  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FRAME: begin
        if (in_byte_q == EndByte || in_byte_q == AbortByte) begin
          state_d = ST_IDLE;
        end else if (in_byte_q == EscapeByte) begin
          state_d = ST_ESC;
        end
      end
      ST_ESC: begin
        if (in_byte_q == CodeStart || in_byte_q == CodeEnd ||
            in_byte_q == CodeAbort || in_byte_q == CodeEscape) begin
          state_d = ST_FRAME;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = (in_byte_q == StartByte) ? ST_FRAME : ST_IDLE;
      end
    endcase
  end

  // Event and payload
  always_comb begin
    ev_d   = EV_NONE;
    data_d = '0;
    unique case (state_q)
      ST_FRAME: begin
        if (in_byte_q == StartByte) begin
          ev_d = EV_RESTART;
        end else if (in_byte_q == EndByte) begin
          ev_d = EV_END;
        end else if (in_byte_q == AbortByte) begin
          ev_d = EV_ABORT;
        end else if (in_byte_q != EscapeByte) begin
          ev_d   = EV_DATA;
          data_d = in_byte_q;
        end
      end
      ST_ESC: begin
        ev_d = EV_DATA;
        case (in_byte_q)
          CodeStart:  data_d = StartByte;
          CodeEnd:    data_d = EndByte;
          CodeAbort:  data_d = AbortByte;
          CodeEscape: data_d = EscapeByte;
          default:    ev_d   = EV_ESCERR;
        endcase
      end
      default: begin
        if (in_byte_q == StartByte) begin
          ev_d = EV_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        state_q <= state_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ev_q   <= ev_d;
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = ev_q;

  // Payload is zero unless the word carries a data byte
  `BSFR_ASSERT(a_data_zero, clk_i, rst_ni,
               (out_valid_q && ev_q != EV_DATA) |-> (data_q == '0))
  // A start or restart always leaves the deframer inside a frame
  `BSFR_ASSERT(a_start_frame, clk_i, rst_ni,
               (out_load && (ev_d == EV_START || ev_d == EV_RESTART))
               |=> (state_q == ST_FRAME))
  // Both registers full and stalled: no word may enter
  `BSFR_ASSERT_NEVER(a_no_overrun, clk_i, rst_ni,
                     in_valid_q && out_valid_q && !m_axis_tready && s_axis_tready)
  // An accepted word into a full input register must move it on
  `BSFR_ASSERT(a_in_moves, clk_i, rst_ni,
               (in_load && in_valid_q) |-> out_load)

endmodule

@@ tb/byte_stuffed_frame_receiver_tb.sv @@
// ----------------------------------------------------------------------------
// Byte stuffed frame receiver testbench
// Drives raw line bytes into s_axis and checks every event word on m_axis
// against a scoreboard that tracks the deframer state on its own. A directed
// sequence covers framing, escape and error cases, then random frames with
// random payload, broken escapes and line noise follow, with bursty stalls
// on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_tb;
  import bsfr_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned LineItems     = 400;

  typedef struct packed {
    logic [EventW-1:0] ev;
    logic [ByteW-1:0]  data;
  } event_word_t;

  class frame_scoreboard;
    state_e      frame_st;
    event_word_t expected_words[$];
    int unsigned errors;

    function new();
      frame_st = ST_IDLE;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    task report(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Advance the deframer state by one accepted line byte.
    function void note_line_byte(input logic [ByteW-1:0] raw);
      event_word_t w;
      w.ev   = EV_NONE;
      w.data = '0;
      case (frame_st)
        ST_FRAME: begin
          if (raw == StartByte) begin
            w.ev = EV_RESTART;
          end else if (raw == EndByte) begin
            w.ev     = EV_END;
            frame_st = ST_IDLE;
          end else if (raw == AbortByte) begin
            w.ev     = EV_ABORT;
            frame_st = ST_IDLE;
          end else if (raw == EscapeByte) begin
            frame_st = ST_ESC;
          end else begin
            w.ev   = EV_DATA;
            w.data = raw;
          end
        end
        ST_ESC: begin
          w.ev     = EV_DATA;
          frame_st = ST_FRAME;
          case (raw)
            CodeStart:  w.data = StartByte;
            CodeEnd:    w.data = EndByte;
            CodeAbort:  w.data = AbortByte;
            CodeEscape: w.data = EscapeByte;
            default: begin
              w.ev     = EV_ESCERR;
              frame_st = ST_IDLE;
            end
          endcase
        end
        default: begin
          if (raw == StartByte) begin
            w.ev     = EV_START;
            frame_st = ST_FRAME;
          end else begin
            frame_st = ST_IDLE;
          end
        end
      endcase
      expected_words.push_back(w);
    endfunction

    task check_event_word(input logic [EventW-1:0] ev, input logic [ByteW-1:0] data);
      event_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word event=%0d data=%02h", ev, data));
      end else begin
        w = expected_words.pop_front();
        if (ev !== w.ev)
          report($sformatf("event %0d, expected %0d", ev, w.ev));
        if (data !== w.data)
          report($sformatf("data %02h, expected %02h (event %0d)", data, w.data, w.ev));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ByteW-1:0] m_axis_tdata;   // [7:0] data_byte
  logic [EventW-1:0] m_axis_tuser;  // [2:0] event_res

  frame_scoreboard sb = new();
  int unsigned line_items = 0;
  int unsigned send_gap_odds = 8;   // 0 turns sender gaps off
  bit          no_idle = 1'b0;
  int unsigned quiet_cycles = 0;

  byte_stuffed_frame_receiver dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Monitor both handshakes on the edge, plus the stall watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_line_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_event_word(m_axis_tuser, m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no word moved for %0d cycles", WatchdogLimit);
        $display("FAIL byte_stuffed_frame_receiver");
        $finish;
      end
    end
  end

  // Result side: random stall bursts until the tail of the run.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  task send_byte(input logic [ByteW-1:0] b, input bit counted);
    if (!no_idle && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (counted) line_items++;
  endtask

  // Stop sending until every event word has come back.
  task drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task send_escaped(input logic [ByteW-1:0] code);
    send_byte(EscapeByte, 1'b1);
    send_byte(code, 1'b1);
  endtask

  // One random frame; mostly well formed, sometimes aborted, broken or open.
  task send_frame();
    int unsigned n;
    int unsigned r;
    logic [ByteW-1:0] b;
    send_byte(StartByte, 1'b1);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    repeat (n) begin
      r = $urandom_range(0, 39);
      if (r == 0) begin
        send_byte(StartByte, 1'b1);
      end else if (r < 25) begin
        b = ByteW'($urandom_range(0, 255));
        case (b)
          StartByte:  send_escaped(CodeStart);
          EndByte:    send_escaped(CodeEnd);
          AbortByte:  send_escaped(CodeAbort);
          EscapeByte: send_escaped(CodeEscape);
          default:    send_byte(b, 1'b1);
        endcase
      end else begin
        case (r % 4)
          0: send_escaped(CodeStart);
          1: send_escaped(CodeEnd);
          2: send_escaped(CodeAbort);
          default: send_escaped(CodeEscape);
        endcase
      end
    end
    r = $urandom_range(0, 9);
    if (r < 7) begin
      send_byte(EndByte, 1'b1);
    end else if (r == 7) begin
      send_byte(AbortByte, 1'b1);
    end else if (r == 8) begin
      send_byte(EscapeByte, 1'b1);
      case ($urandom_range(0, 5))
        0: send_byte(StartByte, 1'b1);
        1: send_byte(EndByte, 1'b1);
        2: send_byte(AbortByte, 1'b1);
        3: send_byte(EscapeByte, 1'b1);
        default: send_byte(ByteW'($urandom_range(0, 255)), 1'b1);
      endcase
    end
    // else: frame left open, the next start byte restarts it
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    bit pressed;
    pressed = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle noise, extremes, every escape code, every event.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(EndByte, 1'b1);       // end while idle is discarded
    send_byte(EscapeByte, 1'b1);    // escape while idle is discarded
    send_byte(StartByte, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_escaped(CodeStart);
    send_escaped(CodeEnd);
    send_escaped(CodeAbort);
    send_escaped(CodeEscape);
    send_byte(StartByte, 1'b1);     // restart inside a frame
    send_escaped(8'h55);            // bad escape code
    send_byte(StartByte, 1'b1);
    send_byte(AbortByte, 1'b1);
    send_byte(StartByte, 1'b1);
    send_byte(8'h5A, 1'b1);
    send_byte(EndByte, 1'b1);
    send_byte(StartByte, 1'b1);
    send_escaped(StartByte);        // framing byte right after escape
    send_byte(StartByte, 1'b1);
    send_escaped(EscapeByte);
    drain_results();

    while (line_items < LineItems) begin
      // vary sender gap density per frame, with some gap-free stretches
      case ($urandom_range(0, 3))
        0: send_gap_odds = 0;
        1: send_gap_odds = 2;
        default: send_gap_odds = 10;
      endcase
      if (line_items >= LineItems - 60) no_idle = 1'b1;
      if (!pressed && line_items >= LineItems / 2) begin
        drain_results();
        pressed = 1'b1;
      end
      send_frame();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("PASS byte_stuffed_frame_receiver");
    else
      $display("FAIL byte_stuffed_frame_receiver");
    $finish;
  end

endmodule
